/* design/yenc_pkg.sv */
// ----------------------------------------------------------------------------
// yenc_pkg
// Shared character codes and the per-byte encode result for the line encoder.
// ----------------------------------------------------------------------------
package yenc_pkg;

   localparam logic [7:0] YENC_OFFSET = 8'd42;
   localparam logic [7:0] ESC_OFFSET  = 8'd64;
   localparam logic [7:0] ESC_CHAR    = 8'h3D;
   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_DOT      = 8'h2E;

   localparam logic [9:0] LINE_LENGTH_RESET = 10'd128;

   // Encoded characters for one input byte, first character in slot 0.
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;
      logic [10:0]     next_column;
   } enc_result_type;

endpackage

/* design/yenc_if.sv */
// ----------------------------------------------------------------------------
// yenc_req_if / yenc_rsp_if
// Valid/ready channels for raw input bytes and encoded output characters.
// ----------------------------------------------------------------------------
interface yenc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface yenc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;

   modport source (output valid, output out_byte, output run_end, input ready);
   modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface

/* design/yenc_char_encoder.sv */
// ----------------------------------------------------------------------------
// yenc_char_encoder
// Maps one raw byte and the current line column to the encoded characters
// (optional CR LF, then a raw or escaped character) and the next column.
// ----------------------------------------------------------------------------
module yenc_char_encoder (
   input  logic [7:0]                data_byte,
   input  logic                      is_last,
   input  logic [10:0]               line_column,
   input  logic [9:0]                line_length,
   output yenc_pkg::enc_result_type  result
);
   import yenc_pkg::*;

   logic [7:0]  v;
   logic [7:0]  v_esc;
   logic        line_full;
   logic [10:0] col_eff;
   logic        is_crit;
   logic        is_blank;
   logic        is_dot;
   logic        mid_line;
   logic        esc_pos;
   logic        esc;

   assign v        = data_byte + YENC_OFFSET;
   assign v_esc    = v + ESC_OFFSET;
   assign line_full = (line_column != 11'd0) && (line_column >= {1'b0, line_length});
   assign col_eff  = line_full ? 11'd0 : line_column;
   assign is_crit  = (v == CH_NUL) || (v == CH_LF) || (v == CH_CR) || (v == ESC_CHAR);
   assign is_blank = (v == CH_TAB) || (v == CH_SPACE);
   assign is_dot   = (v == CH_DOT);
   assign mid_line = ({1'b0, col_eff} + 12'd1) < {2'b00, line_length};

   always_comb begin
      priority if (col_eff == 11'd0) begin
         esc_pos = is_crit | is_blank | is_dot;
      end else if (mid_line) begin
         esc_pos = is_crit;
      end else begin
         esc_pos = is_crit | is_blank;
      end
   end

   // escape a raw trailing blank at the end of a buffer
   assign esc = esc_pos | (is_last & is_blank);

   always_comb begin
      result.chars = '0;
      unique case ({line_full, esc})
         2'b00: begin
            result.chars[0] = v;
            result.last_idx = 2'd0;
         end
         2'b01: begin
            result.chars[0] = ESC_CHAR;
            result.chars[1] = v_esc;
            result.last_idx = 2'd1;
         end
         2'b10: begin
            result.chars[0] = CH_CR;
            result.chars[1] = CH_LF;
            result.chars[2] = v;
            result.last_idx = 2'd2;
         end
         default: begin
            result.chars[0] = CH_CR;
            result.chars[1] = CH_LF;
            result.chars[2] = ESC_CHAR;
            result.chars[3] = v_esc;
            result.last_idx = 2'd3;
         end
      endcase
      result.next_column = col_eff + (esc ? 11'd2 : 11'd1);
   end

endmodule

/* design/yenc_line_encoder.sv */
// ----------------------------------------------------------------------------
// yenc_line_encoder
// Streaming yEnc encoder. Each accepted raw byte yields one to four encoded
// characters: CR LF when the previous line is full, then the character
// (byte + 42) or its two-character escape. The output side sends one
// character per cycle while rsp_bus.ready is high, from a four-slot shift
// register, and the input side takes the next byte in the same cycle the
// last character of the current byte leaves, so a new byte waits until the
// whole group of the last one has been sent. The line column is updated
// as the byte is taken. line_length is written through csr_we / csr_wdata
// and resets to 128.
// ----------------------------------------------------------------------------
module yenc_line_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [9:0]  csr_wdata,
   yenc_req_if.sink    req_bus,
   yenc_rsp_if.source  rsp_bus
);
   import yenc_pkg::*;

   enc_result_type  enc;

   logic [9:0]      line_length_ff;
   logic [10:0]     column_ff;
   logic [10:0]     column_in;
   logic [3:0][7:0] chars_ff;
   logic [3:0][7:0] chars_in;
   logic [1:0]      remain_ff;
   logic [1:0]      remain_in;
   logic            valid_ff;
   logic            valid_in;

   logic            take;
   logic            finishing;
   logic            accept;

   yenc_char_encoder u_encoder (
      .data_byte   (req_bus.data_byte),
      .is_last     (req_bus.is_last),
      .line_column (column_ff),
      .line_length (line_length_ff),
      .result      (enc)
   );

   assign take      = valid_ff & rsp_bus.ready;
   assign finishing = take & (remain_ff == 2'd0);
   assign req_bus.ready = ~valid_ff | finishing;
   assign accept    = req_bus.valid & req_bus.ready;

   assign rsp_bus.valid    = valid_ff;
   assign rsp_bus.out_byte = chars_ff[0];
   assign rsp_bus.run_end  = (remain_ff == 2'd0);

   always_comb begin
      chars_in  = chars_ff;
      remain_in = remain_ff;
      valid_in  = valid_ff;
      column_in = column_ff;
      if (accept) begin
         chars_in  = enc.chars;
         remain_in = enc.last_idx;
         valid_in  = 1'b1;
         column_in = enc.next_column;
      end else if (take) begin
         // advance to the next character of this beat group
         chars_in = {8'h00, chars_ff[3:1]};
         if (finishing) begin
            valid_in = 1'b0;
         end else begin
            remain_in = remain_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LINE_LENGTH_RESET;
         column_ff      <= 11'd0;
         remain_ff      <= 2'd0;
         valid_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            line_length_ff <= csr_wdata;
         end
         column_ff <= column_in;
         remain_ff <= remain_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
   end

   // Line column never passes one escape beyond the longest line.
   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      column_ff <= 11'd1024)
      else $error("line column out of range");

   // Pending characters only while the output holds a beat.
   a_remain_idle: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> (remain_ff == 2'd0))
      else $error("characters pending with no output beat");

   // A taken byte shows its full character group on the next cycle.
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> (valid_ff && (remain_ff == $past(enc.last_idx))))
      else $error("accepted byte not loaded into output");

   // An escape marker is always followed by its escaped character.
   a_escape_not_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (chars_ff[0] == ESC_CHAR)) |-> (remain_ff != 2'd0))
      else $error("escape marker ended a run");

endmodule
